@@ hdl/pcm_capture_level_stats_defines.svh @@
// Assertion helpers for the capture statistics RTL.
`ifndef PCM_CAPTURE_LEVEL_STATS_DEFINES_SVH
`define PCM_CAPTURE_LEVEL_STATS_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define PCS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/pcs_pkg.sv @@
package pcs_pkg;

   localparam int COUNT_BITS = 24;
   localparam int SAMPLE_W   = 16;
   localparam int CNT_W      = COUNT_BITS;
   localparam int RAW_W      = COUNT_BITS + 2;
   localparam int ACC_W      = COUNT_BITS + 15;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;

   localparam logic [CNT_W-1:0] TARGET_RESET = CNT_W'(16000);

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] mono_sample;
      logic signed [SAMPLE_W-1:0] min_level;
      logic signed [SAMPLE_W-1:0] max_level;
      logic [CNT_W-1:0]           nonzero_total;
      logic [CNT_W-1:0]           left_nonzero_total;
      logic [CNT_W-1:0]           right_nonzero_total;
      logic [CNT_W-1:0]           clip_low_total;
      logic [CNT_W-1:0]           clip_high_total;
      logic [ACC_W-1:0]           magnitude_sum;
      logic [CNT_W-1:0]           samples_taken;
      logic [RAW_W-1:0]           nonzero_byte_total;
      logic                       capture_done;
   } rsp_payload_type;

   // Saturating increment of a counter.
   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v, input logic en);
      logic [CNT_W-1:0] r;
      r = v;
      if (en && (v != {CNT_W{1'b1}})) begin
         r = v + CNT_W'(1);
      end
      return r;
   endfunction

endpackage

@@ hdl/pcs_req_if.sv @@
interface pcs_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [pcs_pkg::SAMPLE_W-1:0] left_sample;
   logic signed [pcs_pkg::SAMPLE_W-1:0] right_sample;
   logic                                start_new;

   modport source (output valid, left_sample, right_sample, start_new, input ready);
   modport sink   (input valid, left_sample, right_sample, start_new, output ready);
endinterface

@@ hdl/pcs_rsp_if.sv @@
interface pcs_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [pcs_pkg::SAMPLE_W-1:0] mono_sample;
   logic signed [pcs_pkg::SAMPLE_W-1:0] min_level;
   logic signed [pcs_pkg::SAMPLE_W-1:0] max_level;
   logic [pcs_pkg::CNT_W-1:0]           nonzero_total;
   logic [pcs_pkg::CNT_W-1:0]           left_nonzero_total;
   logic [pcs_pkg::CNT_W-1:0]           right_nonzero_total;
   logic [pcs_pkg::CNT_W-1:0]           clip_low_total;
   logic [pcs_pkg::CNT_W-1:0]           clip_high_total;
   logic [pcs_pkg::ACC_W-1:0]           magnitude_sum;
   logic [pcs_pkg::CNT_W-1:0]           samples_taken;
   logic [pcs_pkg::RAW_W-1:0]           nonzero_byte_total;
   logic                                capture_done;

   modport source (output valid, mono_sample, min_level, max_level, nonzero_total,
                   left_nonzero_total, right_nonzero_total, clip_low_total,
                   clip_high_total, magnitude_sum, samples_taken, nonzero_byte_total,
                   capture_done, input ready);
   modport sink   (input valid, mono_sample, min_level, max_level, nonzero_total,
                   left_nonzero_total, right_nonzero_total, clip_low_total,
                   clip_high_total, magnitude_sum, samples_taken, nonzero_byte_total,
                   capture_done, output ready);
endinterface

@@ hdl/pcm_capture_level_stats.sv @@
// Capture level statistics: each request carries one stereo frame; the left
// sample is the mono capture sample, and each captured frame yields one
// response with the sample and the running min/max, nonzero, clip, magnitude,
// sample and raw-byte counts (all saturating). Once samples_taken reaches
// csr target_samples (reset 16000) frames are dropped with no response until
// a request with start_new set, which clears the statistics and opens a new
// capture with that frame. Throughput is one request per clock while the
// response side is not stalled; a response passes the input register, then
// the statistics update into the response register. req ready falls only when
// both the input register and the response register hold undelivered data.
// Write target_samples only while no request is in flight.

`include "pcm_capture_level_stats_defines.svh"

module pcm_capture_level_stats (
   input  logic                        clock,
   input  logic                        reset,
   pcs_req_if.sink                     req_bus,
   pcs_rsp_if.source                   rsp_bus,
   input  logic                        csr_write_enable,
   input  logic [pcs_pkg::CNT_W-1:0]   csr_write_data
);

   localparam int SW = pcs_pkg::SAMPLE_W;
   localparam int CW = pcs_pkg::CNT_W;
   localparam int RW = pcs_pkg::RAW_W;
   localparam int AW = pcs_pkg::ACC_W;

   // configuration
   logic [CW-1:0] target_ff;

   // input register stage
   logic                 in_valid_ff, in_valid_in;
   logic signed [SW-1:0] in_left_ff;
   logic signed [SW-1:0] in_right_ff;
   logic                 in_start_ff;

   // running statistics
   logic signed [SW-1:0] run_min_ff, run_min_in;
   logic signed [SW-1:0] run_max_ff, run_max_in;
   logic [CW-1:0] cnt_nonzero_ff, cnt_nonzero_in;
   logic [CW-1:0] cnt_left_ff, cnt_left_in;
   logic [CW-1:0] cnt_right_ff, cnt_right_in;
   logic [CW-1:0] cnt_clip_low_ff, cnt_clip_low_in;
   logic [CW-1:0] cnt_clip_high_ff, cnt_clip_high_in;
   logic [AW-1:0] abs_acc_ff, abs_acc_in;
   logic [CW-1:0] cnt_samples_ff, cnt_samples_in;
   logic [RW-1:0] cnt_raw_ff, cnt_raw_in;

   // response register
   logic                     rsp_valid_ff, rsp_valid_in;
   pcs_pkg::rsp_payload_type rsp_ff, rsp_in;

   // datapath temporaries
   logic                 advance;      // input stage may move into response stage
   logic                 fire;         // input stage item consumed this cycle
   logic                 stopped;      // capture finished, frame dropped
   logic                 take;         // frame produces a response
   logic signed [SW-1:0] base_min, base_max;
   logic [CW-1:0]        base_nonzero, base_left, base_right;
   logic [CW-1:0]        base_clip_low, base_clip_high, base_samples;
   logic [AW-1:0]        base_acc;
   logic [RW-1:0]        base_raw;
   logic [2:0]           byte_cnt;
   logic [RW:0]          raw_sum;
   logic [SW-1:0]        mag;
   logic [AW:0]          acc_sum;
   logic                 left_nz, right_nz;

   assign advance       = !rsp_valid_ff || rsp_bus.ready;
   assign fire          = in_valid_ff && advance;
   assign req_bus.ready = !in_valid_ff || advance;

   always_comb begin
      // start_new: statistics restart from reset values ahead of this frame
      if (in_start_ff) begin
         base_min       = pcs_pkg::SAMPLE_MAX;
         base_max       = pcs_pkg::SAMPLE_MIN;
         base_nonzero   = '0;
         base_left      = '0;
         base_right     = '0;
         base_clip_low  = '0;
         base_clip_high = '0;
         base_acc       = '0;
         base_samples   = '0;
         base_raw       = '0;
      end else begin
         base_min       = run_min_ff;
         base_max       = run_max_ff;
         base_nonzero   = cnt_nonzero_ff;
         base_left      = cnt_left_ff;
         base_right     = cnt_right_ff;
         base_clip_low  = cnt_clip_low_ff;
         base_clip_high = cnt_clip_high_ff;
         base_acc       = abs_acc_ff;
         base_samples   = cnt_samples_ff;
         base_raw       = cnt_raw_ff;
      end

      stopped = !in_start_ff && (cnt_samples_ff >= target_ff);
      take    = fire && !stopped;

      left_nz  = (in_left_ff != '0);
      right_nz = (in_right_ff != '0);

      // nonzero bytes among the frame's four raw bytes
      byte_cnt = 3'(in_left_ff[7:0] != 8'd0) + 3'(in_left_ff[15:8] != 8'd0)
               + 3'(in_right_ff[7:0] != 8'd0) + 3'(in_right_ff[15:8] != 8'd0);
      raw_sum  = {1'b0, base_raw} + (RW+1)'(byte_cnt);

      // |left|; -32768 maps to 0x8000, which still fits unsigned 16 bits
      mag     = in_left_ff[SW-1] ? SW'(-in_left_ff) : SW'(in_left_ff);
      acc_sum = {1'b0, base_acc} + (AW+1)'(mag);

      run_min_in       = (in_left_ff < base_min) ? in_left_ff : base_min;
      run_max_in       = (in_left_ff > base_max) ? in_left_ff : base_max;
      cnt_nonzero_in   = pcs_pkg::sat_inc(base_nonzero, left_nz);
      cnt_left_in      = pcs_pkg::sat_inc(base_left, left_nz);
      cnt_right_in     = pcs_pkg::sat_inc(base_right, right_nz);
      cnt_clip_low_in  = pcs_pkg::sat_inc(base_clip_low, in_left_ff == pcs_pkg::SAMPLE_MIN);
      cnt_clip_high_in = pcs_pkg::sat_inc(base_clip_high, in_left_ff == pcs_pkg::SAMPLE_MAX);
      cnt_samples_in   = pcs_pkg::sat_inc(base_samples, 1'b1);
      cnt_raw_in       = raw_sum[RW] ? {RW{1'b1}} : raw_sum[RW-1:0];
      abs_acc_in       = acc_sum[AW] ? {AW{1'b1}} : acc_sum[AW-1:0];

      rsp_in.mono_sample         = in_left_ff;
      rsp_in.min_level           = run_min_in;
      rsp_in.max_level           = run_max_in;
      rsp_in.nonzero_total       = cnt_nonzero_in;
      rsp_in.left_nonzero_total  = cnt_left_in;
      rsp_in.right_nonzero_total = cnt_right_in;
      rsp_in.clip_low_total      = cnt_clip_low_in;
      rsp_in.clip_high_total     = cnt_clip_high_in;
      rsp_in.magnitude_sum       = abs_acc_in;
      rsp_in.samples_taken       = cnt_samples_in;
      rsp_in.nonzero_byte_total  = cnt_raw_in;
      rsp_in.capture_done        = (cnt_samples_in >= target_ff);

      // response slot: refilled by a taken frame, emptied once delivered
      if (advance) begin
         rsp_valid_in = take;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      // input slot: loaded on request accept, emptied when consumed
      if (req_bus.valid && req_bus.ready) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // control and statistics state
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff        <= pcs_pkg::TARGET_RESET;
         in_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         run_min_ff       <= pcs_pkg::SAMPLE_MAX;
         run_max_ff       <= pcs_pkg::SAMPLE_MIN;
         cnt_nonzero_ff   <= '0;
         cnt_left_ff      <= '0;
         cnt_right_ff     <= '0;
         cnt_clip_low_ff  <= '0;
         cnt_clip_high_ff <= '0;
         abs_acc_ff       <= '0;
         cnt_samples_ff   <= '0;
         cnt_raw_ff       <= '0;
      end else begin
         if (csr_write_enable) begin
            target_ff <= csr_write_data;
         end
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            run_min_ff       <= run_min_in;
            run_max_ff       <= run_max_in;
            cnt_nonzero_ff   <= cnt_nonzero_in;
            cnt_left_ff      <= cnt_left_in;
            cnt_right_ff     <= cnt_right_in;
            cnt_clip_low_ff  <= cnt_clip_low_in;
            cnt_clip_high_ff <= cnt_clip_high_in;
            abs_acc_ff       <= abs_acc_in;
            cnt_samples_ff   <= cnt_samples_in;
            cnt_raw_ff       <= cnt_raw_in;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_left_ff  <= req_bus.left_sample;
         in_right_ff <= req_bus.right_sample;
         in_start_ff <= req_bus.start_new;
      end
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_bus.valid               = rsp_valid_ff;
   assign rsp_bus.mono_sample         = rsp_ff.mono_sample;
   assign rsp_bus.min_level           = rsp_ff.min_level;
   assign rsp_bus.max_level           = rsp_ff.max_level;
   assign rsp_bus.nonzero_total       = rsp_ff.nonzero_total;
   assign rsp_bus.left_nonzero_total  = rsp_ff.left_nonzero_total;
   assign rsp_bus.right_nonzero_total = rsp_ff.right_nonzero_total;
   assign rsp_bus.clip_low_total      = rsp_ff.clip_low_total;
   assign rsp_bus.clip_high_total     = rsp_ff.clip_high_total;
   assign rsp_bus.magnitude_sum       = rsp_ff.magnitude_sum;
   assign rsp_bus.samples_taken       = rsp_ff.samples_taken;
   assign rsp_bus.nonzero_byte_total  = rsp_ff.nonzero_byte_total;
   assign rsp_bus.capture_done        = rsp_ff.capture_done;

   // a taken frame shows up as a response carrying the updated sample count
   `PCS_ASSERT_NEXT(a_take_to_rsp, clock, reset, take,
      rsp_valid_ff && (rsp_ff.samples_taken == cnt_samples_ff),
      "taken frame did not produce matching response")

   // once any sample is captured the running min cannot exceed the max
   `PCS_ASSERT_SAME(a_min_le_max, clock, reset, cnt_samples_ff != '0,
      run_min_ff <= run_max_ff, "running min above running max")

   // every clip-high sample is also a nonzero sample, and nonzero never exceeds samples
   `PCS_ASSERT_SAME(a_clip_le_nonzero, clock, reset, 1'b1,
      (cnt_clip_high_ff <= cnt_nonzero_ff) && (cnt_nonzero_ff <= cnt_samples_ff),
      "statistics counters out of order")

endmodule
